@@ rtl/twg_pkg.sv @@
// Shared types, constants and elaboration-time helpers of the test waveform generator.
// Used by twg_ctrl, twg_dp and test_waveform_generator; depends on nothing.
package twg_pkg;

    localparam int MAX_TONES_DEF   = 16;
    localparam int SINE_DEPTH_DEF  = 1024;

    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 24;
    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int STEP_W     = 32;
    localparam int MODE_W     = 2;
    localparam int TCOUNT_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SIN_W      = 17;
    localparam int PROD_W     = 66;

    localparam logic [KIND_W-1:0] KIND_NEXT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TONES  = 3'd6;

    localparam logic [INDEX_W-1:0]  COUNT_RST  = 24'd1024;
    localparam logic [VALUE_W-1:0]  PULSE_RST  = 32'h0001_0000;
    localparam logic [VALUE_W-1:0]  GAIN_RST   = 32'h0001_0000;
    localparam logic [VALUE_W-1:0]  SLOPE_RST  = 32'h0001_0000;
    localparam logic [VALUE_W-1:0]  OFFSET_RST = 32'h0000_0000;
    localparam logic [TCOUNT_W-1:0] TONES_RST  = 5'd1;

    // pi/2 in unsigned Q60
    localparam logic [63:0] PI_HALF_Q60 = 64'h1921_FB54_442D_1846;

    typedef enum logic [MODE_W-1:0] {
        MODE_BOX   = 2'd0,
        MODE_SPIKE = 2'd1,
        MODE_LINE  = 2'd2,
        MODE_SINE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        MUL_IDX_SLOPE = 2'd0,
        MUL_GAIN_LINE = 2'd1,
        MUL_GAIN_SINE = 2'd2
    } mul_op_t;

    typedef enum logic [1:0] {
        VAL_PULSE = 2'd0,
        VAL_LINE  = 2'd1,
        VAL_SINE  = 2'd2
    } val_sel_t;

    typedef struct packed {
        logic     idx_clear;
        logic     idx_advance;
        logic     phase_clear;
        logic     step_we;
        logic     tone_issue;
        logic     acc_clear;
        logic     mul_en;
        mul_op_t  mul_op;
        logic     lv_load;
        logic     val_load;
        val_sel_t val_sel;
        logic     out_load;
    } twg_cmd_t;

    typedef struct packed {
        logic busy;
        logic last;
    } twg_status_t;

    // (a*b) >> 60, low 64 bits
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // sin(x) in unsigned Q1.16 from x in Q60, by a Taylor series of thirteen terms
    function automatic logic [SIN_W-1:0] sine_from_x(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        sh;
        x2   = mul_q60(x, x);
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 12; n++) begin
            term = mul_q60(term, x2) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        sh = ($unsigned(sum) + (64'd1 << 43)) >> 44;
        return sh[SIN_W-1:0];
    endfunction

endpackage

@@ rtl/twg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the tone phase and tone step tables.
module twg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/twg_ctrl.sv @@
// Sequencing state machine of the test waveform generator.
// Depends on twg_pkg; drives twg_dp through twg_cmd_t and reads twg_status_t.
module twg_ctrl #(
    parameter int MAX_TONES = twg_pkg::MAX_TONES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [twg_pkg::KIND_W-1:0]            s_kind,
    input  twg_pkg::mode_t                        mode,
    input  logic [twg_pkg::TCOUNT_W-1:0]          tone_count,
    input  logic                                  out_free,
    input  twg_pkg::twg_status_t                  status,
    output twg_pkg::twg_cmd_t                     cmd,
    output logic [((MAX_TONES > 1) ? $clog2(MAX_TONES) : 1)-1:0] tone_addr
);
    import twg_pkg::*;

    localparam int TONE_AW = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
    localparam int TCNT_W  = $clog2(MAX_TONES + 1);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_LN_MUL1 = 8'b0000_0010,
        ST_LN_ADD  = 8'b0000_0100,
        ST_LN_MUL2 = 8'b0000_1000,
        ST_LN_RND  = 8'b0001_0000,
        ST_SN_ISS  = 8'b0010_0000,
        ST_SN_DRN  = 8'b0100_0000,
        ST_EMIT    = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [TCNT_W-1:0]   tone_reg, tone_next;
    logic [TCNT_W-1:0]   active;

    assign active = ({27'd0, tone_count} > 32'(MAX_TONES)) ? TCNT_W'(MAX_TONES)
                                                           : TCNT_W'(tone_count);
    assign tone_addr = tone_reg[TONE_AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tone_reg  <= '0;
        end else begin
            state_reg <= state_next;
            tone_reg  <= tone_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        tone_next  = tone_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_kind == KIND_NEXT) begin
                        cmd.acc_clear = 1'b1;
                        tone_next     = '0;
                        unique case (mode)
                            MODE_BOX, MODE_SPIKE: begin
                                cmd.val_load = 1'b1;
                                cmd.val_sel  = VAL_PULSE;
                                state_next   = ST_EMIT;
                            end
                            MODE_LINE: state_next = ST_LN_MUL1;
                            MODE_SINE: state_next = ST_SN_ISS;
                        endcase
                    end else if (s_kind == KIND_RESTART) begin
                        cmd.idx_clear   = 1'b1;
                        cmd.phase_clear = 1'b1;
                    end else if (s_kind == KIND_LOAD) begin
                        cmd.step_we = 1'b1;
                    end
                end
            end
            ST_LN_MUL1: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_IDX_SLOPE;
                state_next = ST_LN_ADD;
            end
            ST_LN_ADD: begin
                cmd.lv_load = 1'b1;
                state_next  = ST_LN_MUL2;
            end
            ST_LN_MUL2: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_GAIN_LINE;
                state_next = ST_LN_RND;
            end
            ST_LN_RND: begin
                cmd.val_load = 1'b1;
                cmd.val_sel  = VAL_LINE;
                state_next   = ST_EMIT;
            end
            ST_SN_ISS: begin
                cmd.mul_op = MUL_GAIN_SINE;
                if (tone_reg == active) begin
                    state_next = ST_SN_DRN;
                end else begin
                    cmd.tone_issue = 1'b1;
                    tone_next      = tone_reg + 1'b1;
                end
            end
            ST_SN_DRN: begin
                cmd.mul_op = MUL_GAIN_SINE;
                if (!status.busy) begin
                    cmd.val_load = 1'b1;
                    cmd.val_sel  = VAL_SINE;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    if (status.last) begin
                        cmd.idx_clear   = 1'b1;
                        cmd.phase_clear = 1'b1;
                    end else begin
                        cmd.idx_advance = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

@@ rtl/twg_dp.sv @@
// Datapath: sample index, tone tables, sine table, shared multiplier, accumulator.
// Depends on twg_pkg and twg_ram; commanded by twg_ctrl.
module twg_dp #(
    parameter int MAX_TONES        = twg_pkg::MAX_TONES_DEF,
    parameter int SINE_TABLE_DEPTH = twg_pkg::SINE_DEPTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  twg_pkg::twg_cmd_t                     cmd,
    input  logic [((MAX_TONES > 1) ? $clog2(MAX_TONES) : 1)-1:0] tone_addr,
    input  twg_pkg::mode_t                        mode,
    input  logic [twg_pkg::INDEX_W-1:0]           sample_count,
    input  logic [twg_pkg::VALUE_W-1:0]           pulse_level,
    input  logic [twg_pkg::VALUE_W-1:0]           gain,
    input  logic [twg_pkg::VALUE_W-1:0]           line_slope,
    input  logic [twg_pkg::VALUE_W-1:0]           line_offset,
    input  logic [twg_pkg::SLOT_W-1:0]            load_slot,
    input  logic [twg_pkg::STEP_W-1:0]            load_step,
    output twg_pkg::twg_status_t                  status,
    output logic [twg_pkg::VALUE_W-1:0]           value,
    output logic [twg_pkg::INDEX_W-1:0]           index
);
    import twg_pkg::*;

    localparam int TONE_AW = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
    localparam int POS_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PP_W    = 30 + POS_W;
    localparam int ACC_W   = VALUE_W + 1 + $clog2(MAX_TONES + 1);
    localparam logic [63:0] QD = PI_HALF_Q60 / SINE_TABLE_DEPTH;
    localparam logic [63:0] RM = PI_HALF_Q60 % SINE_TABLE_DEPTH;
    localparam logic signed [PROD_W-1:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT_MIN = -66'sd2147483648;

    function automatic logic [VALUE_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
        if (x > SAT_MAX) begin
            return 32'h7FFF_FFFF;
        end else if (x < SAT_MIN) begin
            return 32'h8000_0000;
        end
        return x[VALUE_W-1:0];
    endfunction

    // quarter-wave sine table, built at elaboration
    logic [SIN_W-1:0] rom_tab [SINE_TABLE_DEPTH + 1];
    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] XK = QD * 64'(k) + (RM * 64'(k)) / SINE_TABLE_DEPTH;
        assign rom_tab[k] = sine_from_x(XK);
    end

    // ---- record index ----
    logic [INDEX_W-1:0] idx_reg;
    logic [INDEX_W-1:0] cnt, half, quarter;
    logic               box_hit, spike_hit, pulse_hit;

    assign cnt       = (sample_count == '0) ? INDEX_W'(1) : sample_count;
    assign half      = cnt >> 1;
    assign quarter   = half >> 1;
    assign box_hit   = (idx_reg >= quarter) &&
                       ({1'b0, idx_reg} < ({1'b0, half} + {1'b0, quarter}));
    assign spike_hit = (idx_reg == half);
    assign pulse_hit = (mode == MODE_SPIKE) ? spike_hit : box_hit;
    assign status.last = (({1'b0, idx_reg} + 1'b1) >= {1'b0, cnt});

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.idx_clear) begin
            idx_reg <= '0;
        end else if (cmd.idx_advance) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // ---- tone tables ----
    logic [MAX_TONES-1:0] pvalid_reg, svalid_reg;
    logic [STEP_W-1:0]    ph_rd, st_rd, ph_cur, st_cur, ph_new;
    logic [TONE_AW-1:0]   addr1_reg;
    logic                 pv1_reg, sv1_reg;
    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                 slot_ok;

    assign slot_ok = ({28'd0, load_slot} < 32'(MAX_TONES));

    twg_ram #(.WIDTH(STEP_W), .DEPTH(MAX_TONES)) u_phase (
        .aclk  (aclk),
        .we    (v1_reg),
        .waddr (addr1_reg),
        .wdata (ph_new),
        .raddr (tone_addr),
        .rdata (ph_rd)
    );

    twg_ram #(.WIDTH(STEP_W), .DEPTH(MAX_TONES)) u_step (
        .aclk  (aclk),
        .we    (cmd.step_we && slot_ok),
        .waddr (TONE_AW'(load_slot)),
        .wdata (load_step),
        .raddr (tone_addr),
        .rdata (st_rd)
    );

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.phase_clear) begin
            pvalid_reg <= '0;
        end else if (v1_reg) begin
            pvalid_reg[addr1_reg] <= 1'b1;
        end
        if (!aresetn) begin
            svalid_reg <= '0;
        end else if (cmd.step_we && slot_ok) begin
            svalid_reg[TONE_AW'(load_slot)] <= 1'b1;
        end
    end

    // ---- sine pipeline ----
    logic [PP_W-1:0]          pos_prod;
    logic [POS_W-1:0]         pos2_reg, rom_addr;
    logic [1:0]               quad2_reg;
    logic [SIN_W-1:0]         mag3_reg;
    logic                     neg3_reg;
    logic signed [SIN_W:0]    sin_s;

    assign ph_cur   = pv1_reg ? ph_rd : '0;
    assign st_cur   = sv1_reg ? st_rd : '0;
    assign ph_new   = ph_cur + st_cur;
    assign pos_prod = PP_W'(ph_cur[29:0]) * PP_W'(SINE_TABLE_DEPTH);
    assign rom_addr = quad2_reg[0] ? (POS_W'(SINE_TABLE_DEPTH) - pos2_reg) : pos2_reg;
    assign sin_s    = neg3_reg ? -$signed({1'b0, mag3_reg}) : $signed({1'b0, mag3_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.tone_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
        addr1_reg <= tone_addr;
        pv1_reg   <= pvalid_reg[tone_addr];
        sv1_reg   <= svalid_reg[tone_addr];
        pos2_reg  <= pos_prod[PP_W-1:30];
        quad2_reg <= ph_cur[31:30];
        mag3_reg  <= rom_tab[rom_addr];
        neg3_reg  <= quad2_reg[1];
    end

    assign status.busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;

    // ---- shared multiplier and rounding ----
    logic signed [32:0]        mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_reg, rnd;
    logic [VALUE_W-1:0]        rnd_sat, lv_reg, term5_reg, val_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    always_comb begin
        case (cmd.mul_op)
            MUL_IDX_SLOPE: begin
                mul_a = $signed({9'd0, idx_reg});
                mul_b = $signed({line_slope[31], line_slope});
            end
            MUL_GAIN_LINE: begin
                mul_a = $signed({gain[31], gain});
                mul_b = $signed({lv_reg[31], lv_reg});
            end
            default: begin
                mul_a = $signed({gain[31], gain});
                mul_b = $signed({{(33 - SIN_W - 1){sin_s[SIN_W]}}, sin_s});
            end
        endcase
    end

    assign rnd     = (prod_reg + 66'sd32768) >>> 16;
    assign rnd_sat = sat32(rnd);

    always_ff @(posedge aclk) begin
        if (cmd.mul_en || v3_reg) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.lv_load) begin
            lv_reg <= sat32(prod_reg + {{(PROD_W - VALUE_W){line_offset[31]}}, line_offset});
        end
        if (v4_reg) begin
            term5_reg <= rnd_sat;
        end
        if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (v5_reg) begin
            acc_reg <= acc_reg + {{(ACC_W - VALUE_W){term5_reg[31]}}, term5_reg};
        end
        if (cmd.val_load) begin
            case (cmd.val_sel)
                VAL_PULSE: val_reg <= pulse_hit ? pulse_level : '0;
                VAL_LINE:  val_reg <= rnd_sat;
                default:   val_reg <= sat32({{(PROD_W - ACC_W){acc_reg[ACC_W-1]}}, acc_reg});
            endcase
        end
    end

    assign value = val_reg;
    assign index = idx_reg;
endmodule

@@ rtl/test_waveform_generator.sv @@
// Top level of the test waveform generator: configuration registers, output register.
// Depends on twg_pkg, twg_ctrl, twg_dp and twg_ram.
//
// One sample comes out per next-sample request, in box, spike, line or sum-of-sines
// mode, as signed Q16.16 with saturation. Box and spike samples go from the idle state
// straight to the emit state; line samples pass twice through the shared 33x33
// multiplier. Sine samples stream the tones one per cycle through a six-stage pipeline
// (phase/step RAM read, table index, sine table read, multiply, round, accumulate),
// and the sum is taken once it drains. Restart and load requests give no output.
// The output register lets a request be taken while a finished sample still waits.
module test_waveform_generator #(
    parameter int MAX_TONES        = twg_pkg::MAX_TONES_DEF,
    parameter int SINE_TABLE_DEPTH = twg_pkg::SINE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [39:0]                       s_tdata,  // tone_slot[3:0], phase_step[35:4]
    input  logic [twg_pkg::KIND_W-1:0]        s_tuser,  // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [55:0]                       m_tdata,  // sample_value[31:0], sample_index[55:32]
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [twg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [twg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import twg_pkg::*;

    localparam int TONE_AW = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;

    mode_t                mode_reg;
    logic [INDEX_W-1:0]   count_reg;
    logic [VALUE_W-1:0]   pulse_reg, gain_reg, slope_reg, offset_reg;
    logic [TCOUNT_W-1:0]  tones_reg;

    logic                 cfg_we;
    twg_cmd_t             cmd;
    twg_status_t          status;
    logic [TONE_AW-1:0]   tone_addr;
    logic [VALUE_W-1:0]   dp_value;
    logic [INDEX_W-1:0]   dp_index;

    logic                 m_tvalid_reg;
    logic [VALUE_W-1:0]   m_value_reg;
    logic [INDEX_W-1:0]   m_index_reg;
    logic                 m_last_reg;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_BOX;
            count_reg  <= COUNT_RST;
            pulse_reg  <= PULSE_RST;
            gain_reg   <= GAIN_RST;
            slope_reg  <= SLOPE_RST;
            offset_reg <= OFFSET_RST;
            tones_reg  <= TONES_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= mode_t'(cfg_data[MODE_W-1:0]);
                REG_COUNT:  count_reg  <= cfg_data[INDEX_W-1:0];
                REG_PULSE:  pulse_reg  <= cfg_data;
                REG_GAIN:   gain_reg   <= cfg_data;
                REG_SLOPE:  slope_reg  <= cfg_data;
                REG_OFFSET: offset_reg <= cfg_data;
                REG_TONES:  tones_reg  <= cfg_data[TCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    twg_ctrl #(.MAX_TONES(MAX_TONES)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_kind     (s_tuser),
        .mode       (mode_reg),
        .tone_count (tones_reg),
        .out_free   (!m_tvalid_reg || m_tready),
        .status     (status),
        .cmd        (cmd),
        .tone_addr  (tone_addr)
    );

    twg_dp #(.MAX_TONES(MAX_TONES), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .tone_addr    (tone_addr),
        .mode         (mode_reg),
        .sample_count (count_reg),
        .pulse_level  (pulse_reg),
        .gain         (gain_reg),
        .line_slope   (slope_reg),
        .line_offset  (offset_reg),
        .load_slot    (s_tdata[3:0]),
        .load_step    (s_tdata[35:4]),
        .status       (status),
        .value        (dp_value),
        .index        (dp_index)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_value_reg <= dp_value;
            m_index_reg <= dp_index;
            m_last_reg  <= status.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_index_reg, m_value_reg};
    assign m_tlast  = m_last_reg;

    // a waiting sample is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten");

    // the sine pipeline has drained before a new request is taken
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !status.busy)
        else $error("request taken while tone pipeline busy");

    // the record restarts after its final sample
    a_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && status.last) |=> (dp_index == '0))
        else $error("index not cleared after last sample");
endmodule
